// File: rtl/core/ps2dl_pkg.sv
// ps2dl_pkg: shared constants, types and frame helper for the ps2 device packet link
// depends on nothing; used by ps2dl_queue and ps2_device_packet_link_core
package ps2dl_pkg;

    // default sizing handed down from the top level
    localparam int QUEUE_DEPTH_DEF      = 32;
    localparam int MAX_PACKET_BYTES_DEF = 8;

    localparam logic [7:0]  BUSY_TIMEOUT_RST = 8'd100;
    localparam logic [7:0]  RESEND_CODE      = 8'hFE;
    localparam logic [10:0] FRAME_INVERT     = 11'h7FF;

    // item kinds carried on s_tuser
    localparam logic REQ_POLL = 1'b0;
    localparam logic REQ_PUSH = 1'b1;

    // input tdata layout (push_last on tlast, req_type on tuser)
    localparam int IN_DATA_W      = 24;
    localparam int IN_PUSH_BYTE   = 0;
    localparam int IN_LINE_BUSY   = 8;
    localparam int IN_CLOCK_HIGH  = 9;
    localparam int IN_DATA_HIGH   = 10;
    localparam int IN_TX_FAILED   = 11;
    localparam int IN_RX_VALID    = 12;
    localparam int IN_RX_DATA     = 13;
    localparam int IN_RX_PARITY   = 21;

    // output tdata layout
    localparam int OUT_DATA_W     = 48;
    localparam int OUT_USED_W     = 43;

    typedef struct packed {
        logic       push;
        logic [7:0] push_byte;
        logic       push_last;
        logic       pop;
        logic       flush;
    } q_cmd_t;

    typedef struct packed {
        logic empty;
        logic full;
    } q_stat_t;

    typedef struct packed {
        logic       push_dropped;
        logic [7:0] prev_cmd_byte;
        logic [7:0] cmd_byte;
        logic       cmd_valid;
        logic       fail_ack;
        logic [10:0] reply_frame;
        logic       reply_valid;
        logic [10:0] frame;
        logic       frame_valid;
    } result_t;

    // frame of start 0, data lsb first, odd parity, stop 1, returned with every bit inverted
    function automatic logic [10:0] line_frame(input logic [7:0] b);
        logic [10:0] v;
        v = {1'b1, ~^b, b, 1'b0};
        return v ^ FRAME_INVERT;
    endfunction

endpackage

// File: rtl/core/ps2_device_packet_link_core.sv
// ps2_device_packet_link_core: an accepted item is held in the item registers while
// the packet memories are read, then the update writes its result into the output
// register that drives m_tvalid; a new item is taken only after the last one's update,
// and a result still waiting on m_tready holds back the next update until it is taken
// reset: rst_n asynchronous active low clears pointers, counters, last bytes and the
// output valid flag and loads busy_timeout with 100; memories are not cleared
module ps2_device_packet_link_core
    import ps2dl_pkg::*;
#(
    parameter int QUEUE_DEPTH      = QUEUE_DEPTH_DEF,
    parameter int MAX_PACKET_BYTES = MAX_PACKET_BYTES_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    // configuration: busy_timeout
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [7:0]            cfg_data,
    // input items
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // push_byte[7:0], line_busy[8], clock_high[9], data_high[10], tx_failed[11],
    // rx_valid[12], rx_data[20:13], rx_parity[21], zero[23:22]
    input  logic [IN_DATA_W-1:0]  s_tdata,
    input  logic                  s_tuser,   // req_type
    input  logic                  s_tlast,   // push_last
    // result items
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // frame_valid[0], frame[11:1], reply_valid[12], reply_frame[23:13], fail_ack[24],
    // cmd_valid[25], cmd_byte[33:26], prev_cmd_byte[41:34], push_dropped[42], zero[47:43]
    output logic [OUT_DATA_W-1:0] m_tdata
);

    localparam int CW = $clog2(MAX_PACKET_BYTES + 1);
    localparam int IW = (MAX_PACKET_BYTES > 1) ? $clog2(MAX_PACKET_BYTES) : 1;

    typedef enum logic {ST_IDLE, ST_EXEC} state_t;

    state_t                 state_reg, state_next;
    logic [IN_DATA_W-1:0]   item_data_reg;
    logic                   item_type_reg;
    logic                   item_last_reg;
    logic [CW-1:0]          bytes_sent_reg, bytes_sent_next;
    logic [7:0]             busy_cnt_reg, busy_cnt_next;
    logic [7:0]             last_sent_reg, last_sent_next;
    logic [7:0]             last_cmd_reg, last_cmd_next;
    logic [7:0]             busy_timeout_reg;
    logic                   out_valid_reg, out_valid_next;
    result_t                out_res_reg, out_res_next;

    q_cmd_t                 q_cmd;
    q_stat_t                q_stat;
    logic                   q_dropped;
    logic [CW-1:0]          q_len;
    logic [7:0]             q_byte;

    logic                   in_xact;
    logic                   commit;
    logic                   is_push;
    logic                   poll_pop;
    logic                   poll_flush;

    // unpacked fields of the held item
    logic       line_busy, clock_high, data_high, tx_failed, rx_valid, rx_parity;
    logic [7:0] rx_data;

    assign line_busy  = item_data_reg[IN_LINE_BUSY];
    assign clock_high = item_data_reg[IN_CLOCK_HIGH];
    assign data_high  = item_data_reg[IN_DATA_HIGH];
    assign tx_failed  = item_data_reg[IN_TX_FAILED];
    assign rx_valid   = item_data_reg[IN_RX_VALID];
    assign rx_data    = item_data_reg[IN_RX_DATA +: 8];
    assign rx_parity  = item_data_reg[IN_RX_PARITY];

    // config register may be written any cycle
    assign cfg_ready = 1'b1;

    // new items come in only between updates; the output register decouples the sink
    assign s_tready = (state_reg == ST_IDLE);
    assign in_xact  = s_tvalid && s_tready;
    // the update lands only when the output register can take its result
    assign commit   = (state_reg == ST_EXEC) && (!out_valid_reg || m_tready);
    assign is_push  = (item_type_reg == REQ_PUSH);

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {(OUT_DATA_W - OUT_USED_W)'(0), out_res_reg};

    // queue commands: push writes the staging slot, pop and flush move the head
    always_comb
    begin
        q_cmd.push      = commit && is_push;
        q_cmd.push_byte = item_data_reg[IN_PUSH_BYTE +: 8];
        q_cmd.push_last = item_last_reg;
        q_cmd.pop       = commit && !is_push && poll_pop;
        q_cmd.flush     = commit && !is_push && poll_flush;
    end

    // poll tick: timeout, send or pop, failure step back, host byte handling
    always_comb
    begin
        logic [7:0]  cd;
        logic [CW-1:0] bs;
        logic [7:0]  ls;
        logic        send_ok;
        result_t     res;

        cd         = busy_cnt_reg;
        bs         = bytes_sent_reg;
        ls         = last_sent_reg;
        res        = '0;
        poll_pop   = 1'b0;
        poll_flush = 1'b0;
        last_cmd_next = last_cmd_reg;

        if (cd != '0)
        begin
            cd = line_busy ? 8'd0 : cd - 8'd1;
        end

        send_ok = (cd == '0) && !line_busy && data_high && clock_high && !q_stat.empty;
        if (send_ok)
        begin
            if (bs >= q_len)
            begin
                // whole packet went out
                poll_pop = 1'b1;
                bs       = '0;
            end
            else
            begin
                bs              = bs + 1'b1;
                ls              = q_byte;
                cd              = busy_timeout_reg;
                res.frame_valid = 1'b1;
                res.frame       = line_frame(q_byte);
            end
        end

        if (tx_failed)
        begin
            if (bs != '0)
            begin
                bs = bs - 1'b1;
            end
            res.fail_ack = 1'b1;
        end

        if (rx_valid)
        begin
            if ((~^rx_data) != rx_parity)
            begin
                // bad parity: ask the host to resend
                res.reply_valid = 1'b1;
                res.reply_frame = line_frame(RESEND_CODE);
            end
            else if (rx_data == RESEND_CODE)
            begin
                res.reply_valid = 1'b1;
                res.reply_frame = line_frame(ls);
            end
            else
            begin
                // host command drops everything queued
                poll_flush        = 1'b1;
                bs                = '0;
                res.cmd_valid     = 1'b1;
                res.cmd_byte      = rx_data;
                res.prev_cmd_byte = last_cmd_reg;
                last_cmd_next     = rx_data;
            end
        end

        bytes_sent_next = bs;
        busy_cnt_next   = cd;
        last_sent_next  = ls;
        out_res_next    = res;

        if (is_push)
        begin
            // push touches only the staging side
            bytes_sent_next  = bytes_sent_reg;
            busy_cnt_next    = busy_cnt_reg;
            last_sent_next   = last_sent_reg;
            last_cmd_next    = last_cmd_reg;
            out_res_next     = '0;
            out_res_next.push_dropped = q_dropped;
        end
    end

    // sequencing
    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !m_tready;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_xact)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (commit)
                begin
                    state_next     = ST_IDLE;
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            bytes_sent_reg   <= '0;
            busy_cnt_reg     <= '0;
            last_sent_reg    <= '0;
            last_cmd_reg     <= '0;
            busy_timeout_reg <= BUSY_TIMEOUT_RST;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                busy_timeout_reg <= cfg_data;
            end
            if (commit)
            begin
                bytes_sent_reg <= bytes_sent_next;
                busy_cnt_reg   <= busy_cnt_next;
                last_sent_reg  <= last_sent_next;
                last_cmd_reg   <= last_cmd_next;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_xact)
        begin
            item_data_reg <= s_tdata;
            item_type_reg <= s_tuser;
            item_last_reg <= s_tlast;
        end
        if (commit)
        begin
            out_res_reg <= out_res_next;
        end
    end

    ps2dl_queue #(
        .QUEUE_DEPTH      (QUEUE_DEPTH),
        .MAX_PACKET_BYTES (MAX_PACKET_BYTES)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (q_cmd),
        .rd_idx    (bytes_sent_reg[IW-1:0]),
        .stat      (q_stat),
        .dropped   (q_dropped),
        .head_len  (q_len),
        .head_byte (q_byte)
    );

    // an accepted transaction always moves on to the update cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        in_xact |=> (state_reg == ST_EXEC))
        else $error("accepted item did not enter update");

    // a result appears only as the product of an update
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(commit))
        else $error("result without update");

    // a resend reply and a host command never come from the same tick
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tdata[12] && m_tdata[25]))
        else $error("reply and command in one result");

    // the send position never passes the largest packet
    assert property (@(posedge clk) disable iff (!rst_n)
        bytes_sent_reg <= CW'(MAX_PACKET_BYTES))
        else $error("bytes_sent out of range");

endmodule

// File: rtl/core/ps2dl_ram.sv
// ps2dl_ram: generic simple dual-port ram, one write port, one registered read port
// depends on nothing
module ps2dl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// File: rtl/core/ps2dl_queue.sv
// ps2dl_queue: packet queue with byte store, length store and ring pointers
// depends on ps2dl_pkg and ps2dl_ram
module ps2dl_queue
    import ps2dl_pkg::*;
#(
    parameter int QUEUE_DEPTH      = QUEUE_DEPTH_DEF,
    parameter int MAX_PACKET_BYTES = MAX_PACKET_BYTES_DEF,
    localparam int CW = $clog2(MAX_PACKET_BYTES + 1),
    localparam int IW = (MAX_PACKET_BYTES > 1) ? $clog2(MAX_PACKET_BYTES) : 1
) (
    input  logic          clk,
    input  logic          rst_n,
    input  q_cmd_t        cmd,
    input  logic [IW-1:0] rd_idx,
    output q_stat_t       stat,
    output logic          dropped,
    output logic [CW-1:0] head_len,
    output logic [7:0]    head_byte
);

    // one spare slot: the slot under the tail pointer is always free for staging
    localparam int NS  = QUEUE_DEPTH + 1;
    localparam int SW  = $clog2(NS);
    localparam int QCW = $clog2(QUEUE_DEPTH + 1);
    localparam int BYTE_DEPTH = 1 << (SW + IW);
    localparam int LEN_DEPTH  = 1 << SW;

    logic [SW-1:0]  head_reg, head_next;
    logic [SW-1:0]  tail_reg, tail_next;
    logic [QCW-1:0] count_reg, count_next;
    logic [CW-1:0]  stage_reg, stage_next;

    logic           byte_wr, len_wr;
    logic [CW-1:0]  stage_inc;
    logic [SW-1:0]  head_inc, tail_inc;

    assign stat.empty = (count_reg == '0);
    assign stat.full  = (count_reg == QCW'(QUEUE_DEPTH));
    assign head_inc   = (head_reg == SW'(NS - 1)) ? '0 : head_reg + 1'b1;
    assign tail_inc   = (tail_reg == SW'(NS - 1)) ? '0 : tail_reg + 1'b1;
    assign byte_wr    = cmd.push && (stage_reg < CW'(MAX_PACKET_BYTES));
    assign stage_inc  = byte_wr ? stage_reg + 1'b1 : stage_reg;
    assign len_wr     = cmd.push && cmd.push_last && !stat.full;
    assign dropped    = cmd.push && cmd.push_last && stat.full;

    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        stage_next = stage_reg;
        if (cmd.push)
        begin
            stage_next = cmd.push_last ? '0 : stage_inc;
            if (len_wr)
            begin
                tail_next  = tail_inc;
                count_next = count_reg + 1'b1;
            end
        end
        if (cmd.flush)
        begin
            head_next  = tail_reg;
            count_next = '0;
        end
        else if (cmd.pop)
        begin
            head_next  = head_inc;
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
            stage_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
            stage_reg <= stage_next;
        end
    end

    ps2dl_ram #(
        .WIDTH (8),
        .DEPTH (BYTE_DEPTH)
    ) u_byte_ram (
        .clk     (clk),
        .wr_en   (byte_wr),
        .wr_addr ({tail_reg, stage_reg[IW-1:0]}),
        .wr_data (cmd.push_byte),
        .rd_addr ({head_reg, rd_idx}),
        .rd_data (head_byte)
    );

    ps2dl_ram #(
        .WIDTH (CW),
        .DEPTH (LEN_DEPTH)
    ) u_len_ram (
        .clk     (clk),
        .wr_en   (len_wr),
        .wr_addr (tail_reg),
        .wr_data (stage_inc),
        .rd_addr (head_reg),
        .rd_data (head_len)
    );

endmodule
